// ----- rtl/min_queue_two_stacks_defines.svh -----
// Assertion macros for the two-stack minimum queue.
// Used at the end of the top level; assumes signals clk and rst_n are in scope.
`ifndef MIN_QUEUE_TWO_STACKS_DEFINES_SVH
`define MIN_QUEUE_TWO_STACKS_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MQTS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define MQTS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/mqts_pkg.sv -----
// Shared constants for the two-stack minimum queue: command and status codes
// and the fixed widths of the word fields. No dependencies.
package mqts_pkg;

    // Fixed field widths of the command and response words.
    localparam int FIELD_WIDTH = 32;
    localparam int COUNT_OUT_WIDTH = 9;

    // Command codes; any other code behaves as a peek.
    localparam logic [1:0] CMD_PUSH = 2'd0;
    localparam logic [1:0] CMD_POP = 2'd1;
    localparam logic [1:0] CMD_PEEK = 2'd2;

    // Status codes.
    localparam logic [1:0] STATUS_OK = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL = 2'd2;

endpackage

// ----- rtl/min_queue_two_stacks.sv -----
// Top level of the two-stack minimum queue: FSM, stack memories and response register.
// Depends on mqts_pkg and min_queue_two_stacks_defines.svh.
//
// A first-in first-out store of signed values that reports, with every response word,
// the oldest, newest and smallest value held, the count and a status. One command word
// is handled at a time. A push, a peek, a failed command or a pop that leaves the output
// stack non-empty passes from the cycle that accepts the word, which updates the stacks,
// to the response cycle, which loads the response register. A pop that empties the output
// stack while values wait in the input stack passes through a transfer between the two,
// which walks the input stack memory through its single read port at one entry per cycle.
// While a response word is held by rsp_stall, one further command word may be taken; it
// then waits in its response cycle, with cmd_stall high, until the held word leaves. No
// clearing pass follows reset.
`include "min_queue_two_stacks_defines.svh"

module min_queue_two_stacks
    import mqts_pkg::*;
#(
    parameter int CAPACITY = 256,
    parameter int VALUE_WIDTH = 32
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cmd_valid,
    output logic                              cmd_stall,
    input  logic [1:0]                        command,
    input  logic signed [FIELD_WIDTH-1:0]     push_value,
    output logic                              rsp_valid,
    input  logic                              rsp_stall,
    output logic signed [FIELD_WIDTH-1:0]     popped_value,
    output logic signed [FIELD_WIDTH-1:0]     front_value,
    output logic signed [FIELD_WIDTH-1:0]     back_value,
    output logic signed [FIELD_WIDTH-1:0]     min_value,
    output logic [COUNT_OUT_WIDTH-1:0]        item_count,
    output logic [1:0]                        status
);

    localparam int VW = VALUE_WIDTH;
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW:0] CAP_COUNT = (CW + 1)'(CAPACITY);

    typedef enum logic [1:0] {
        S_IDLE,
        S_XFER,
        S_DONE
    } state_t;

    // Sign-extend a stored value and cut it to the reported width.
    function automatic logic [FIELD_WIDTH-1:0] report(input logic [VW-1:0] v);
        logic [VW+FIELD_WIDTH-1:0] ext;
        ext = {{FIELD_WIDTH{v[VW-1]}}, v};
        return ext[FIELD_WIDTH-1:0];
    endfunction

    // Sign-extend an incoming value and cut it to the stored width.
    function automatic logic [VW-1:0] trim(input logic [FIELD_WIDTH-1:0] v);
        logic [VW+FIELD_WIDTH-1:0] ext;
        ext = {{VW{v[FIELD_WIDTH-1]}}, v};
        return ext[VW-1:0];
    endfunction

    // Signed minimum of two stored values.
    function automatic logic [VW-1:0] smin(input logic [VW-1:0] a, input logic [VW-1:0] b);
        return ($signed(a) <= $signed(b)) ? a : b;
    endfunction

    // Control and cached stack-top registers.
    state_t                     state_reg, state_next;
    logic [CW-1:0]              in_depth_reg, in_depth_next;
    logic [CW-1:0]              out_depth_reg, out_depth_next;
    logic [VW-1:0]              in_top_val_reg, in_top_val_next;
    logic [VW-1:0]              in_top_min_reg, in_top_min_next;
    logic [VW-1:0]              out_top_val_reg, out_top_val_next;
    logic [VW-1:0]              out_top_min_reg, out_top_min_next;
    logic [VW-1:0]              out_bottom_reg, out_bottom_next;
    logic [AW-1:0]              xfer_rd_reg, xfer_rd_next;
    logic [AW-1:0]              xfer_wr_reg, xfer_wr_next;
    logic [VW-1:0]              run_min_reg, run_min_next;
    logic                       reload_reg, reload_next;
    logic [FIELD_WIDTH-1:0]     popped_reg, popped_next;
    logic [1:0]                 status_reg, status_next;

    // Response register.
    logic                       rsp_valid_reg, rsp_valid_next;
    logic [FIELD_WIDTH-1:0]     popped_value_reg, popped_value_next;
    logic [FIELD_WIDTH-1:0]     front_value_reg, front_value_next;
    logic [FIELD_WIDTH-1:0]     back_value_reg, back_value_next;
    logic [FIELD_WIDTH-1:0]     min_value_reg, min_value_next;
    logic [COUNT_OUT_WIDTH-1:0] item_count_reg, item_count_next;
    logic [1:0]                 status_out_reg, status_out_next;

    // Memory ports. The input stack keeps values only; its running minimum is needed
    // at the top alone and lives in in_top_min_reg. The output stack keeps value and
    // minimum side by side.
    logic [VW-1:0]              in_mem [CAPACITY];
    logic                       in_we, in_re;
    logic [AW-1:0]              in_waddr, in_raddr;
    logic [VW-1:0]              in_wdata, in_rdata_reg;
    logic [2*VW-1:0]            out_mem [CAPACITY];
    logic                       out_we, out_re;
    logic [AW-1:0]              out_waddr, out_raddr;
    logic [2*VW-1:0]            out_wdata, out_rdata_reg;

    // Working signals.
    logic                       cmd_take;
    logic                       rsp_free;
    logic [CW:0]                count_now;
    logic [CW-1:0]              in_top_idx;
    logic [CW-1:0]              out_reload_idx;
    logic [VW-1:0]              raw_value;
    logic [VW-1:0]              xfer_val;
    logic [VW-1:0]              xfer_min;
    logic [VW-1:0]              top_val_eff;
    logic [VW-1:0]              top_min_eff;
    logic [CW+COUNT_OUT_WIDTH-1:0] count_wide;

    assign cmd_stall = (state_reg != S_IDLE);
    assign cmd_take = cmd_valid && !cmd_stall;
    assign rsp_free = !rsp_valid_reg || !rsp_stall;
    assign count_now = {1'b0, in_depth_reg} + {1'b0, out_depth_reg};
    assign in_top_idx = in_depth_reg - CW'(1);
    assign out_reload_idx = out_depth_reg - CW'(2);
    assign raw_value = trim(push_value);
    assign xfer_val = in_rdata_reg;
    assign xfer_min = (xfer_wr_reg == '0) ? xfer_val : smin(xfer_val, run_min_reg);
    assign top_val_eff = reload_reg ? out_rdata_reg[2*VW-1:VW] : out_top_val_reg;
    assign top_min_eff = reload_reg ? out_rdata_reg[VW-1:0] : out_top_min_reg;
    assign count_wide = (CW + COUNT_OUT_WIDTH)'(count_now);

    // Input stack memory: one write and one registered read port.
    always_ff @(posedge clk)
    begin
        if (in_we)
        begin
            in_mem[in_waddr] <= in_wdata;
        end
        if (in_re)
        begin
            in_rdata_reg <= in_mem[in_raddr];
        end
    end

    // Output stack memory: one write and one registered read port.
    always_ff @(posedge clk)
    begin
        if (out_we)
        begin
            out_mem[out_waddr] <= out_wdata;
        end
        if (out_re)
        begin
            out_rdata_reg <= out_mem[out_raddr];
        end
    end

    // Next-state logic. Commands are handled one at a time, so a read of an entry
    // never overlaps a write of the same entry.
    always_comb
    begin
        state_next = state_reg;
        in_depth_next = in_depth_reg;
        out_depth_next = out_depth_reg;
        in_top_val_next = in_top_val_reg;
        in_top_min_next = in_top_min_reg;
        out_top_val_next = out_top_val_reg;
        out_top_min_next = out_top_min_reg;
        out_bottom_next = out_bottom_reg;
        xfer_rd_next = xfer_rd_reg;
        xfer_wr_next = xfer_wr_reg;
        run_min_next = run_min_reg;
        reload_next = reload_reg;
        popped_next = popped_reg;
        status_next = status_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        popped_value_next = popped_value_reg;
        front_value_next = front_value_reg;
        back_value_next = back_value_reg;
        min_value_next = min_value_reg;
        item_count_next = item_count_reg;
        status_out_next = status_out_reg;
        in_we = 1'b0;
        in_waddr = in_depth_reg[AW-1:0];
        in_wdata = raw_value;
        in_re = 1'b0;
        in_raddr = in_top_idx[AW-1:0];
        out_we = 1'b0;
        out_waddr = '0;
        out_wdata = {raw_value, raw_value};
        out_re = 1'b0;
        out_raddr = out_reload_idx[AW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_take)
                begin
                    popped_next = '0;
                    status_next = STATUS_OK;
                    reload_next = 1'b0;
                    state_next = S_DONE;
                    if (command == CMD_PUSH)
                    begin
                        if (count_now >= CAP_COUNT)
                        begin
                            status_next = STATUS_FULL;
                        end
                        else if (out_depth_reg == '0)
                        begin
                            // Empty queue: the value goes straight to the output stack.
                            out_we = 1'b1;
                            out_depth_next = CW'(1);
                            out_top_val_next = raw_value;
                            out_top_min_next = raw_value;
                            out_bottom_next = raw_value;
                        end
                        else
                        begin
                            in_we = 1'b1;
                            in_depth_next = in_depth_reg + CW'(1);
                            in_top_val_next = raw_value;
                            in_top_min_next = (in_depth_reg == '0) ? raw_value
                                : smin(raw_value, in_top_min_reg);
                        end
                    end
                    else if (command == CMD_POP)
                    begin
                        if (out_depth_reg == '0)
                        begin
                            status_next = STATUS_EMPTY;
                        end
                        else
                        begin
                            popped_next = report(out_top_val_reg);
                            out_depth_next = out_depth_reg - CW'(1);
                            if (out_depth_reg >= CW'(2))
                            begin
                                // Fetch the entry below the old top.
                                out_re = 1'b1;
                                reload_next = 1'b1;
                            end
                            else if (in_depth_reg != '0)
                            begin
                                // Output stack runs dry: start moving the input stack.
                                in_re = 1'b1;
                                xfer_rd_next = out_reload_idx[AW-1:0] + in_depth_reg[AW-1:0]
                                    - AW'(1);
                                xfer_wr_next = '0;
                                out_bottom_next = in_top_val_reg;
                                state_next = S_XFER;
                            end
                        end
                    end
                end
            end

            S_XFER:
            begin
                // One entry a cycle, top of the input stack first.
                out_we = 1'b1;
                out_waddr = xfer_wr_reg;
                out_wdata = {xfer_val, xfer_min};
                run_min_next = xfer_min;
                if (CW'(xfer_wr_reg) == in_top_idx)
                begin
                    out_depth_next = in_depth_reg;
                    in_depth_next = '0;
                    out_top_val_next = xfer_val;
                    out_top_min_next = xfer_min;
                    state_next = S_DONE;
                end
                else
                begin
                    in_re = 1'b1;
                    in_raddr = xfer_rd_reg;
                    xfer_rd_next = xfer_rd_reg - AW'(1);
                    xfer_wr_next = xfer_wr_reg + AW'(1);
                end
            end

            S_DONE:
            begin
                // Take over the fetched output-stack top once.
                if (reload_reg)
                begin
                    out_top_val_next = top_val_eff;
                    out_top_min_next = top_min_eff;
                    reload_next = 1'b0;
                end
                if (rsp_free)
                begin
                    rsp_valid_next = 1'b1;
                    popped_value_next = popped_reg;
                    status_out_next = status_reg;
                    item_count_next = count_wide[COUNT_OUT_WIDTH-1:0];
                    if (out_depth_reg == '0)
                    begin
                        front_value_next = '0;
                        back_value_next = '0;
                        min_value_next = '0;
                    end
                    else
                    begin
                        front_value_next = report(top_val_eff);
                        if (in_depth_reg != '0)
                        begin
                            back_value_next = report(in_top_val_reg);
                            min_value_next = report(smin(in_top_min_reg, top_min_eff));
                        end
                        else
                        begin
                            back_value_next = report(out_bottom_reg);
                            min_value_next = report(top_min_eff);
                        end
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            in_depth_reg <= '0;
            out_depth_reg <= '0;
            reload_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            in_depth_reg <= in_depth_next;
            out_depth_reg <= out_depth_next;
            reload_reg <= reload_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Cached tops, transfer pointers and response payload; no reset needed.
    always_ff @(posedge clk)
    begin
        in_top_val_reg <= in_top_val_next;
        in_top_min_reg <= in_top_min_next;
        out_top_val_reg <= out_top_val_next;
        out_top_min_reg <= out_top_min_next;
        out_bottom_reg <= out_bottom_next;
        xfer_rd_reg <= xfer_rd_next;
        xfer_wr_reg <= xfer_wr_next;
        run_min_reg <= run_min_next;
        popped_reg <= popped_next;
        status_reg <= status_next;
        popped_value_reg <= popped_value_next;
        front_value_reg <= front_value_next;
        back_value_reg <= back_value_next;
        min_value_reg <= min_value_next;
        item_count_reg <= item_count_next;
        status_out_reg <= status_out_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign popped_value = popped_value_reg;
    assign front_value = front_value_reg;
    assign back_value = back_value_reg;
    assign min_value = min_value_reg;
    assign item_count = item_count_reg;
    assign status = status_out_reg;

    // Between commands, an empty output stack means an empty queue.
    `MQTS_ASSERT_NOW(a_out_empty_means_empty, (state_reg == S_IDLE) && (out_depth_reg == '0), in_depth_reg == '0, "input stack holds values while output stack is empty")
    // The two stacks together never hold more than the capacity.
    `MQTS_ASSERT_NOW(a_count_bound, 1'b1, count_now <= CAP_COUNT, "stored count exceeds capacity")
    // A fetched output-stack top is consumed only in the response cycle.
    `MQTS_ASSERT_NOW(a_reload_in_done, reload_reg, state_reg == S_DONE, "pending reload outside response cycle")
    // An accepted command word raises cmd_stall in the cycle after it.
    `MQTS_ASSERT_NEXT(a_one_at_a_time, cmd_take, cmd_stall, "command accepted while another is in progress")

endmodule

// ----- tb/mqts_reply_checker.sv -----
// Response checker for the two-stack minimum queue: watches both channels, keeps its own
// picture of the queue contents and compares every response word field by field.
// Depends on mqts_pkg; instantiated beside the block by min_queue_two_stacks_tb.
module mqts_reply_checker
    import mqts_pkg::*;
#(
    parameter int CAPACITY = 256
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    input  logic                          cmd_stall,
    input  logic [1:0]                    command,
    input  logic signed [FIELD_WIDTH-1:0] push_value,
    input  logic                          rsp_valid,
    input  logic                          rsp_stall,
    input  logic signed [FIELD_WIDTH-1:0] popped_value,
    input  logic signed [FIELD_WIDTH-1:0] front_value,
    input  logic signed [FIELD_WIDTH-1:0] back_value,
    input  logic signed [FIELD_WIDTH-1:0] min_value,
    input  logic [COUNT_OUT_WIDTH-1:0]    item_count,
    input  logic [1:0]                    status,
    output int                            fail_count,
    output int                            pending
);

    typedef struct packed {
        logic signed [FIELD_WIDTH-1:0] popped;
        logic signed [FIELD_WIDTH-1:0] front;
        logic signed [FIELD_WIDTH-1:0] back;
        logic signed [FIELD_WIDTH-1:0] minimum;
        logic [COUNT_OUT_WIDTH-1:0]    count;
        logic [1:0]                    status;
    } queue_reply_t;

    // The queue is modelled as a plain ordered list; how the block splits it across its
    // two stacks never shows in a response word.
    logic signed [FIELD_WIDTH-1:0] held_words[$];
    queue_reply_t                  reply_expected[$];
    queue_reply_t                  want;
    int                            failures;

    // Applies one command to the modelled queue and returns the response it should give.
    function automatic queue_reply_t apply_command(input logic [1:0] cmd,
                                                   input logic signed [FIELD_WIDTH-1:0] value);
        queue_reply_t                  r;
        logic signed [FIELD_WIDTH-1:0] lowest;
        r = '0;
        if (cmd == CMD_PUSH)
        begin
            if (held_words.size() >= CAPACITY)
                r.status = STATUS_FULL;
            else
                held_words.insert(held_words.size(), value);
        end
        else if (cmd == CMD_POP)
        begin
            if (held_words.size() == 0)
                r.status = STATUS_EMPTY;
            else
                r.popped = held_words.pop_front();
        end
        // Any other code leaves the queue alone and only reports it.
        r.count = COUNT_OUT_WIDTH'(held_words.size());
        if (held_words.size() != 0)
        begin
            r.front = held_words[0];
            r.back = held_words[$];
            lowest = held_words[0];
            foreach (held_words[i])
            begin
                if (held_words[i] < lowest)
                    lowest = held_words[i];
            end
            r.minimum = lowest;
        end
        return r;
    endfunction

    // Reports one field and returns one when it differs from what was predicted.
    function automatic int field_differs(input string name,
                                         input logic signed [FIELD_WIDTH-1:0] exp,
                                         input logic signed [FIELD_WIDTH-1:0] got);
        if (got !== exp)
        begin
            $error("%s: expected %0d, got %0d", name, exp, got);
            return 1;
        end
        return 0;
    endfunction

    // Response words are compared before the command word of the same edge is predicted,
    // since a response can never belong to a word taken at that very edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_words.delete();
            reply_expected.delete();
            failures = 0;
            fail_count <= 0;
            pending <= 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (reply_expected.size() == 0)
                begin
                    $error("response word arrived with no command outstanding");
                    failures++;
                end
                else
                begin
                    want = reply_expected.pop_front();
                    failures += field_differs("popped_value", want.popped, popped_value);
                    failures += field_differs("front_value", want.front, front_value);
                    failures += field_differs("back_value", want.back, back_value);
                    failures += field_differs("min_value", want.minimum, min_value);
                    failures += field_differs("item_count", $signed({23'd0, want.count}),
                                              $signed({23'd0, item_count}));
                    failures += field_differs("status", $signed({30'd0, want.status}),
                                              $signed({30'd0, status}));
                end
            end
            if (cmd_valid && !cmd_stall)
                reply_expected.insert(reply_expected.size(),
                                      apply_command(command, push_value));
            fail_count <= failures;
            pending <= reply_expected.size();
        end
    end

endmodule

// ----- tb/min_queue_two_stacks_tb.sv -----
// Testbench top for the two-stack minimum queue: clock, reset, command stimulus, response
// back-pressure and the final verdict. Depends on mqts_pkg, min_queue_two_stacks and
// mqts_reply_checker.
module min_queue_two_stacks_tb;

    import mqts_pkg::*;

    localparam int CAPACITY = 256;
    localparam int VALUE_WIDTH = 32;
    localparam int CLK_PERIOD = 10;
    localparam int LONG_HOLD = 300;
    localparam int TIMEOUT_CYCLES = 200000;

    // The spare command code, which the block treats as a peek.
    localparam logic [1:0] CMD_SPARE = 2'd3;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          cmd_valid = 1'b0;
    logic                          cmd_stall;
    logic [1:0]                    command = CMD_PEEK;
    logic signed [FIELD_WIDTH-1:0] push_value = '0;
    logic                          rsp_valid;
    logic                          rsp_stall = 1'b0;
    logic signed [FIELD_WIDTH-1:0] popped_value;
    logic signed [FIELD_WIDTH-1:0] front_value;
    logic signed [FIELD_WIDTH-1:0] back_value;
    logic signed [FIELD_WIDTH-1:0] min_value;
    logic [COUNT_OUT_WIDTH-1:0]    item_count;
    logic [1:0]                    status;

    int   fail_count;
    int   pending;
    int   sender_idle_pct = 0;
    int   recv_stall_pct = 0;
    logic hold_toggle = 1'b0;
    logic hold_seen = 1'b0;
    int   hold_left = 0;

    min_queue_two_stacks #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd_stall    (cmd_stall),
        .command      (command),
        .push_value   (push_value),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .popped_value (popped_value),
        .front_value  (front_value),
        .back_value   (back_value),
        .min_value    (min_value),
        .item_count   (item_count),
        .status       (status)
    );

    mqts_reply_checker #(
        .CAPACITY (CAPACITY)
    ) reply_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd_stall    (cmd_stall),
        .command      (command),
        .push_value   (push_value),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .popped_value (popped_value),
        .front_value  (front_value),
        .back_value   (back_value),
        .min_value    (min_value),
        .item_count   (item_count),
        .status       (status),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    always
    begin
        #(CLK_PERIOD / 2) clk = 1'b1;
        #(CLK_PERIOD / 2) clk = 1'b0;
    end

    // Response back-pressure. A flip of hold_toggle starts one long hold-off, counted here,
    // during which the block may take one further word and must then stall its command input.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            rsp_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_seen != hold_toggle)
        begin
            hold_seen <= hold_toggle;
            hold_left <= LONG_HOLD - 1;
            rsp_stall <= 1'b1;
        end
        else
        begin
            rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // Offers one command word, with random idle cycles before it, and waits until taken.
    task automatic send_word(input logic [1:0] cmd, input logic signed [FIELD_WIDTH-1:0] value);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        command <= cmd;
        push_value <= value;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
    endtask

    // Stops offering words until every response outstanding has come back.
    task automatic drain();
        cmd_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    // Values lean towards the extremes and a narrow band round zero, so that equal values
    // and minimum changes are frequent; the rest are fully random.
    function automatic logic signed [FIELD_WIDTH-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'sh7FFF_FFFF - int'($urandom_range(0, 3));
            1: return 32'sh8000_0000 + int'($urandom_range(0, 3));
            2, 3: return int'($urandom_range(0, 32)) - 16;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [1:0] pick_command(input int push_pct, input int pop_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < push_pct)
            return CMD_PUSH;
        if (roll < push_pct + pop_pct)
            return CMD_POP;
        return $urandom_range(0, 1) ? CMD_PEEK : CMD_SPARE;
    endfunction

    task automatic run_phase(input int words, input int push_pct, input int pop_pct,
                             input int idle_pct, input int stall_pct);
        sender_idle_pct = idle_pct;
        recv_stall_pct <= stall_pct;
        repeat (words)
            send_word(pick_command(push_pct, pop_pct), pick_value());
        drain();
    endtask

    // Stimulus and verdict.
    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words: commands on an empty queue, extreme values, the spare code,
        // a pop that forces the transfer between stacks, and draining back to empty.
        send_word(CMD_POP, 32'sd0);
        send_word(CMD_PEEK, 32'sd0);
        send_word(CMD_SPARE, 32'sd0);
        send_word(CMD_PUSH, 32'sh7FFF_FFFF);
        send_word(CMD_PUSH, 32'sh8000_0000);
        send_word(CMD_PUSH, 32'sd0);
        send_word(CMD_PUSH, -32'sd1);
        send_word(CMD_PEEK, 32'sh5A5A_5A5A);
        send_word(CMD_SPARE, -32'sd1);
        send_word(CMD_POP, 32'sd0);
        send_word(CMD_PUSH, 32'sd5);
        send_word(CMD_POP, 32'sd0);
        send_word(CMD_POP, 32'sd0);
        send_word(CMD_PEEK, 32'sd0);
        send_word(CMD_POP, 32'sd0);
        send_word(CMD_POP, 32'sd0);
        send_word(CMD_POP, 32'sd0);
        send_word(CMD_PUSH, 32'shAAAA_AAAA);
        send_word(CMD_PUSH, 32'sh5555_5555);
        send_word(CMD_POP, 32'sd0);
        send_word(CMD_POP, 32'sd0);
        drain();

        // Mixed traffic at full rate.
        run_phase(120, 50, 35, 0, 0);
        // Mostly pushes until the queue is full and pushes are refused; idle sender.
        run_phase(320, 92, 6, 53, 0);
        // Mixed traffic around the full mark with a stalling receiver.
        run_phase(120, 50, 35, 0, 53);
        // Mostly pops down to empty and beyond, both sides idling.
        run_phase(320, 6, 90, 28, 28);
        // A long receiver hold-off while words keep being offered.
        hold_toggle <= ~hold_toggle;
        run_phase(50, 50, 35, 0, 0);

        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Watchdog for a block that stops handshaking.
    initial
    begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
